### sv/nm2d_pkg.sv
// nm2d_pkg: shared constants of the 2-D simplex minimizer.
// Holds register indexes, register reset values and default widths.
// No dependencies.
package nm2d_pkg;

  localparam int COORD_WIDTH_DEF      = 32;
  localparam int PASS_COUNT_WIDTH_DEF = 16;

  localparam int TGT_W      = 32;
  localparam int VAL_W      = 64;
  localparam int ITER_W     = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] REG_TARGET_X  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_Y  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER  = 3'd3;

  localparam logic signed [TGT_W-1:0] TARGET_X_RST  = 32'sd16777216;
  localparam logic signed [TGT_W-1:0] TARGET_Y_RST  = -32'sd83886080;
  localparam logic [VAL_W-1:0]        THRESHOLD_RST = 64'd281;
  localparam logic [ITER_W-1:0]       MAX_ITER_RST  = 16'd1000;

endpackage

### sv/nm2d_sq_unit.sv
// nm2d_sq_unit: shared squaring unit with a registered product.
// Squares a signed difference; the result is ready in the next cycle.
// No dependencies.
module nm2d_sq_unit #(
  parameter int DW = 33
) (
  input  logic                   clk_i,
  input  logic signed [DW-1:0]   diff_i,
  output logic [2*DW-1:0]        sq_o
);

  logic [DW-1:0]   mag;
  logic [2*DW-1:0] sq_q;

  assign mag = diff_i[DW-1] ? DW'(-diff_i) : DW'(diff_i);

  always_ff @(posedge clk_i) begin
    sq_q <= (2*DW)'(mag) * (2*DW)'(mag);
  end

  assign sq_o = sq_q;

endmodule

### sv/nelder_mead_2d_minimizer_unit.sv
// nelder_mead_2d_minimizer_unit: 2-D simplex minimizer of a squared-distance bowl.
// Depends on nm2d_pkg and nm2d_sq_unit.
//
//   channel | signals                               | direction
//   in      | in_valid_i, in_stall_o, start_*_i     | into block
//   out     | out_valid_o, out_stall_i, best_*_o... | out of block
//   cfg     | cfg_we_i, cfg_idx_i, cfg_wdata_i      | into block
//
// After a transfer the block computes the vertex values, sorts them and checks
// the spread, then runs simplex passes, some of which shrink, all through
// the one shared squaring unit; a last step loads the result.
// Reset clears all state and loads register defaults; no clearing pass.
// in_stall_o is high from a transfer until the result is loaded into the
// output register; a stalled output holds the block in its final step.
module nelder_mead_2d_minimizer_unit #(
  parameter int COORD_WIDTH      = nm2d_pkg::COORD_WIDTH_DEF,
  parameter int PASS_COUNT_WIDTH = nm2d_pkg::PASS_COUNT_WIDTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [COORD_WIDTH-1:0]       start_ax_i,
  input  logic signed [COORD_WIDTH-1:0]       start_ay_i,
  input  logic signed [COORD_WIDTH-1:0]       start_bx_i,
  input  logic signed [COORD_WIDTH-1:0]       start_by_i,
  input  logic signed [COORD_WIDTH-1:0]       start_cx_i,
  input  logic signed [COORD_WIDTH-1:0]       start_cy_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [COORD_WIDTH-1:0]       best_x_o,
  output logic signed [COORD_WIDTH-1:0]       best_y_o,
  output logic [nm2d_pkg::VAL_W-1:0]          best_value_o,
  output logic [PASS_COUNT_WIDTH-1:0]         passes_taken_o,
  output logic                                hit_limit_o,
  input  logic                                cfg_we_i,
  input  logic [nm2d_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [nm2d_pkg::CFG_DATA_W-1:0]     cfg_wdata_i
);
  import nm2d_pkg::*;

  localparam int CW   = COORD_WIDTH;
  localparam int PW   = PASS_COUNT_WIDTH;
  localparam int DW   = ((CW > TGT_W) ? CW : TGT_W) + 1;
  localparam int SQW  = 2 * DW;
  localparam int PSW  = SQW + 2;
  localparam int T6W  = VAL_W + 3;
  localparam int CMPW = (PSW > T6W) ? PSW : T6W;
  localparam int TW   = CW + 3;
  localparam int CNTW = (PW > ITER_W) ? PW : ITER_W;

  typedef enum logic [3:0] {
    ST_IDLE, ST_EVAL, ST_INIT_WB, ST_SORT, ST_SETTLE, ST_CHECK,
    ST_PA, ST_PB, ST_PC, ST_DECIDE, ST_SHRINK_WB, ST_DONE
  } st_e;

  st_e st_q, ret_q;

  logic signed [TGT_W-1:0] tgt_x_q, tgt_y_q;
  logic [VAL_W-1:0]        thr_q;
  logic [ITER_W-1:0]       maxit_q;

  logic signed [CW-1:0] vx_q [3];
  logic signed [CW-1:0] vy_q [3];
  logic [VAL_W-1:0]     vv_q [3];
  logic signed [CW-1:0] ptx_q [4];
  logic signed [CW-1:0] pty_q [4];
  logic [VAL_W-1:0]     pv_q [4];
  logic signed [CW-1:0] cx_q, cy_q;
  logic [2:0]           n_q;
  logic [3:0]           s_q;
  logic [VAL_W-1:0]     acc_q;
  logic [PSW-1:0]       psum_q;
  logic                 settle_q;
  logic [PW-1:0]        pass_q;
  logic                 hit_q;

  logic                 out_valid_q;
  logic signed [CW-1:0] best_x_q, best_y_q;
  logic [VAL_W-1:0]     best_v_q;
  logic [PW-1:0]        best_p_q;
  logic                 best_h_q;

  // shared squaring unit operand
  logic [1:0]           idx;
  logic [3:0]           jm;
  logic signed [DW-1:0] d_bowl, d_set, sq_in;
  logic [SQW-1:0]       sq_res;
  logic [VAL_W-1:0]     sq_sat;
  logic [VAL_W:0]       val_sum;
  logic [VAL_W-1:0]     val_sat;
  logic                 ax_first, ax_last;
  logic [PSW-1:0]       psum_next;
  logic [T6W-1:0]       thr6;
  logic                 ax_ok;

  assign idx = s_q[2:1];
  assign jm  = s_q - 4'd1;

  assign d_bowl = s_q[0] ? (DW'(pty_q[idx]) - DW'(tgt_y_q))
                         : (DW'(ptx_q[idx]) - DW'(tgt_x_q));

  always_comb begin
    case (s_q)
      4'd0:    d_set = DW'(vx_q[0]) - DW'(vx_q[1]);
      4'd1:    d_set = DW'(vx_q[1]) - DW'(vx_q[2]);
      4'd2:    d_set = DW'(vx_q[0]) - DW'(vx_q[2]);
      4'd3:    d_set = DW'(vy_q[0]) - DW'(vy_q[1]);
      4'd4:    d_set = DW'(vy_q[1]) - DW'(vy_q[2]);
      4'd5:    d_set = DW'(vy_q[0]) - DW'(vy_q[2]);
      default: d_set = '0;
    endcase
  end

  assign sq_in = (st_q == ST_SETTLE) ? d_set : d_bowl;

  nm2d_sq_unit #(.DW(DW)) u_sq (
    .clk_i  (clk_i),
    .diff_i (sq_in),
    .sq_o   (sq_res)
  );

  assign sq_sat  = (|sq_res[SQW-1:VAL_W]) ? '1 : sq_res[VAL_W-1:0];
  assign val_sum = {1'b0, acc_q} + {1'b0, sq_sat};
  assign val_sat = val_sum[VAL_W] ? '1 : val_sum[VAL_W-1:0];

  assign ax_first  = (jm == 4'd0) || (jm == 4'd3);
  assign ax_last   = (jm == 4'd2) || (jm == 4'd5);
  assign psum_next = (ax_first ? '0 : psum_q) + PSW'(sq_res);
  assign thr6      = ({3'b000, thr_q} << 2) + ({3'b000, thr_q} << 1);
  assign ax_ok     = CMPW'(psum_next) <= CMPW'(thr6);

  // trial points
  logic signed [CW:0]   sum_x, sum_y;
  logic signed [TW-1:0] dtx, dty, rx_raw, ry_raw, ex_raw, ey_raw;
  logic signed [CW-1:0] rx, ry, ex, ey, ix, iy, ox, oy;
  logic signed [CW:0]   hx, hy, gx, gy;
  logic signed [CW:0]   s1x, s1y, s2x, s2y;
  logic signed [CW-1:0] n1x, n1y, n2x, n2y;

  assign sum_x = (CW+1)'(vx_q[0]) + (CW+1)'(vx_q[1]);
  assign sum_y = (CW+1)'(vy_q[0]) + (CW+1)'(vy_q[1]);

  assign dtx    = TW'(cx_q) - TW'(vx_q[2]);
  assign dty    = TW'(cy_q) - TW'(vy_q[2]);
  assign rx_raw = TW'(cx_q) + dtx;
  assign ry_raw = TW'(cy_q) + dty;
  assign ex_raw = TW'(cx_q) + dtx + (dtx <<< 1);
  assign ey_raw = TW'(cy_q) + dty + (dty <<< 1);

  function automatic logic signed [CW-1:0] sat_c(input logic signed [TW-1:0] v);
    logic ovf;
    ovf = !((&v[TW-1:CW-1]) || (~|v[TW-1:CW-1]));
    if (ovf) begin
      sat_c = v[TW-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
    end else begin
      sat_c = v[CW-1:0];
    end
  endfunction

  assign rx = sat_c(rx_raw);
  assign ry = sat_c(ry_raw);
  assign ex = sat_c(ex_raw);
  assign ey = sat_c(ey_raw);

  assign hx = (CW+1)'(vx_q[2]) - (CW+1)'(cx_q);
  assign hy = (CW+1)'(vy_q[2]) - (CW+1)'(cy_q);
  assign ix = CW'((CW+1)'(cx_q) + (hx >>> 1));
  assign iy = CW'((CW+1)'(cy_q) + (hy >>> 1));

  assign gx = (CW+1)'(ptx_q[0]) - (CW+1)'(cx_q);
  assign gy = (CW+1)'(pty_q[0]) - (CW+1)'(cy_q);
  assign ox = CW'((CW+1)'(cx_q) + (gx >>> 1));
  assign oy = CW'((CW+1)'(cy_q) + (gy >>> 1));

  assign s1x = (CW+1)'(vx_q[1]) - (CW+1)'(vx_q[0]);
  assign s1y = (CW+1)'(vy_q[1]) - (CW+1)'(vy_q[0]);
  assign s2x = (CW+1)'(vx_q[2]) - (CW+1)'(vx_q[0]);
  assign s2y = (CW+1)'(vy_q[2]) - (CW+1)'(vy_q[0]);
  assign n1x = CW'((CW+1)'(vx_q[0]) + (s1x >>> 1));
  assign n1y = CW'((CW+1)'(vy_q[0]) + (s1y >>> 1));
  assign n2x = CW'((CW+1)'(vx_q[0]) + (s2x >>> 1));
  assign n2y = CW'((CW+1)'(vy_q[0]) + (s2y >>> 1));

  // decision
  logic [VAL_W-1:0] f0, f1, f2, fr, fe, fi, fo;
  logic             take_r, go_exp, take_i, take_o, cap;

  assign f0 = vv_q[0];
  assign f1 = vv_q[1];
  assign f2 = vv_q[2];
  assign fr = pv_q[0];
  assign fe = pv_q[1];
  assign fi = pv_q[2];
  assign fo = pv_q[3];

  assign take_r = (fr < f1) && (fr >= f0);
  assign go_exp = fr < f0;
  assign take_i = (fr < f2) && (fi <= fr);
  assign take_o = (fr < f2) && (fo < f2);
  assign cap    = (CNTW'(pass_q) >= CNTW'(maxit_q)) || (&pass_q);

  // sort compare for the current pair
  logic swap01, swap12;
  assign swap01 = vv_q[1] < vv_q[0];
  assign swap12 = vv_q[2] < vv_q[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      ret_q       <= ST_IDLE;
      tgt_x_q     <= TARGET_X_RST;
      tgt_y_q     <= TARGET_Y_RST;
      thr_q       <= THRESHOLD_RST;
      maxit_q     <= MAX_ITER_RST;
      for (int k = 0; k < 3; k++) begin
        vx_q[k] <= '0;
        vy_q[k] <= '0;
        vv_q[k] <= '0;
      end
      for (int k = 0; k < 4; k++) begin
        ptx_q[k] <= '0;
        pty_q[k] <= '0;
        pv_q[k]  <= '0;
      end
      cx_q        <= '0;
      cy_q        <= '0;
      n_q         <= '0;
      s_q         <= '0;
      acc_q       <= '0;
      psum_q      <= '0;
      settle_q    <= 1'b0;
      pass_q      <= '0;
      hit_q       <= 1'b0;
      out_valid_q <= 1'b0;
      best_x_q    <= '0;
      best_y_q    <= '0;
      best_v_q    <= '0;
      best_p_q    <= '0;
      best_h_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_TARGET_X:  tgt_x_q <= cfg_wdata_i[TGT_W-1:0];
          REG_TARGET_Y:  tgt_y_q <= cfg_wdata_i[TGT_W-1:0];
          REG_THRESHOLD: thr_q   <= cfg_wdata_i[VAL_W-1:0];
          REG_MAX_ITER:  maxit_q <= cfg_wdata_i[ITER_W-1:0];
          default: ;
        endcase
      end

      if (out_valid_q && !out_stall_i && st_q != ST_DONE) begin
        out_valid_q <= 1'b0;
      end

      unique case (st_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            vx_q[0]  <= start_ax_i;
            vy_q[0]  <= start_ay_i;
            vx_q[1]  <= start_bx_i;
            vy_q[1]  <= start_by_i;
            vx_q[2]  <= start_cx_i;
            vy_q[2]  <= start_cy_i;
            ptx_q[0] <= start_ax_i;
            pty_q[0] <= start_ay_i;
            ptx_q[1] <= start_bx_i;
            pty_q[1] <= start_by_i;
            ptx_q[2] <= start_cx_i;
            pty_q[2] <= start_cy_i;
            n_q      <= 3'd3;
            s_q      <= '0;
            ret_q    <= ST_INIT_WB;
            pass_q   <= '0;
            st_q     <= ST_EVAL;
          end
        end
        ST_EVAL: begin
          if (s_q != 4'd0) begin
            if (!jm[0]) begin
              acc_q <= sq_sat;
            end else begin
              pv_q[jm[2:1]] <= val_sat;
            end
          end
          if (s_q == {n_q, 1'b0}) begin
            st_q <= ret_q;
          end else begin
            s_q <= s_q + 4'd1;
          end
        end
        ST_INIT_WB: begin
          vv_q[0] <= pv_q[0];
          vv_q[1] <= pv_q[1];
          vv_q[2] <= pv_q[2];
          s_q     <= '0;
          st_q    <= ST_SORT;
        end
        ST_SORT: begin
          if (s_q == 4'd1) begin
            if (swap12) begin
              vx_q[1] <= vx_q[2];
              vy_q[1] <= vy_q[2];
              vv_q[1] <= vv_q[2];
              vx_q[2] <= vx_q[1];
              vy_q[2] <= vy_q[1];
              vv_q[2] <= vv_q[1];
            end
          end else if (swap01) begin
            vx_q[0] <= vx_q[1];
            vy_q[0] <= vy_q[1];
            vv_q[0] <= vv_q[1];
            vx_q[1] <= vx_q[0];
            vy_q[1] <= vy_q[0];
            vv_q[1] <= vv_q[0];
          end
          if (s_q == 4'd2) begin
            s_q  <= '0;
            st_q <= ST_SETTLE;
          end else begin
            s_q <= s_q + 4'd1;
          end
        end
        ST_SETTLE: begin
          if (s_q != 4'd0) begin
            psum_q <= psum_next;
            if (ax_last) begin
              settle_q <= (jm == 4'd2) ? ax_ok : (settle_q & ax_ok);
            end
          end
          if (s_q == 4'd6) begin
            st_q <= ST_CHECK;
          end else begin
            s_q <= s_q + 4'd1;
          end
        end
        ST_CHECK: begin
          if (settle_q) begin
            hit_q <= 1'b0;
            st_q  <= ST_DONE;
          end else if (cap) begin
            hit_q <= 1'b1;
            st_q  <= ST_DONE;
          end else begin
            pass_q <= pass_q + PW'(1);
            st_q   <= ST_PA;
          end
        end
        ST_PA: begin
          cx_q <= CW'(sum_x >>> 1);
          cy_q <= CW'(sum_y >>> 1);
          st_q <= ST_PB;
        end
        ST_PB: begin
          ptx_q[0] <= rx;
          pty_q[0] <= ry;
          ptx_q[1] <= ex;
          pty_q[1] <= ey;
          ptx_q[2] <= ix;
          pty_q[2] <= iy;
          st_q     <= ST_PC;
        end
        ST_PC: begin
          ptx_q[3] <= ox;
          pty_q[3] <= oy;
          n_q      <= 3'd4;
          s_q      <= '0;
          ret_q    <= ST_DECIDE;
          st_q     <= ST_EVAL;
        end
        ST_DECIDE: begin
          s_q  <= '0;
          st_q <= (take_r || go_exp || take_i || take_o) ? ST_SORT : ST_EVAL;
          if (take_r || (go_exp && !(fe < fr))) begin
            vx_q[2] <= ptx_q[0];
            vy_q[2] <= pty_q[0];
            vv_q[2] <= fr;
          end else if (go_exp) begin
            vx_q[2] <= ptx_q[1];
            vy_q[2] <= pty_q[1];
            vv_q[2] <= fe;
          end else if (take_i) begin
            vx_q[2] <= ptx_q[2];
            vy_q[2] <= pty_q[2];
            vv_q[2] <= fi;
          end else if (take_o) begin
            vx_q[2] <= ptx_q[3];
            vy_q[2] <= pty_q[3];
            vv_q[2] <= fo;
          end else begin
            ptx_q[0] <= n1x;
            pty_q[0] <= n1y;
            ptx_q[1] <= n2x;
            pty_q[1] <= n2y;
            n_q      <= 3'd2;
            ret_q    <= ST_SHRINK_WB;
          end
        end
        ST_SHRINK_WB: begin
          vx_q[1] <= ptx_q[0];
          vy_q[1] <= pty_q[0];
          vv_q[1] <= pv_q[0];
          vx_q[2] <= ptx_q[1];
          vy_q[2] <= pty_q[1];
          vv_q[2] <= pv_q[1];
          s_q     <= '0;
          st_q    <= ST_SORT;
        end
        ST_DONE: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q <= 1'b1;
            best_x_q    <= vx_q[0];
            best_y_q    <= vy_q[0];
            best_v_q    <= vv_q[0];
            best_p_q    <= pass_q;
            best_h_q    <= hit_q;
            st_q        <= ST_IDLE;
          end
        end
        default: st_q <= ST_IDLE;
      endcase
    end
  end

  assign in_stall_o     = (st_q != ST_IDLE);
  assign out_valid_o    = out_valid_q;
  assign best_x_o       = best_x_q;
  assign best_y_o       = best_y_q;
  assign best_value_o   = best_v_q;
  assign passes_taken_o = best_p_q;
  assign hit_limit_o    = best_h_q;

  a_load_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(st_q == ST_DONE))
    else $error("result loaded outside final step");

  a_accept_starts_eval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (st_q == ST_EVAL && ret_q == ST_INIT_WB))
    else $error("transfer did not start vertex evaluation");

  a_cap_stops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_CHECK && !settle_q && cap) |=> (st_q == ST_DONE && hit_q))
    else $error("pass cap did not stop the search");

  a_pass_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_PA) |-> (CNTW'(pass_q) <= CNTW'(maxit_q)))
    else $error("pass count ran past the cap");

endmodule

### tb/nm2d_result_checker.sv
// nm2d_result_checker: predicts and checks results of nelder_mead_2d_minimizer_unit.
// Watches the input, output and register channels; keeps its own register copy.
// Depends on nm2d_pkg.
module nm2d_result_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  logic                            in_stall_i,
  input  logic [31:0]                     start_ax_i,
  input  logic [31:0]                     start_ay_i,
  input  logic [31:0]                     start_bx_i,
  input  logic [31:0]                     start_by_i,
  input  logic [31:0]                     start_cx_i,
  input  logic [31:0]                     start_cy_i,
  input  logic                            out_valid_i,
  input  logic                            out_stall_i,
  input  logic [31:0]                     best_x_i,
  input  logic [31:0]                     best_y_i,
  input  logic [63:0]                     best_value_i,
  input  logic [15:0]                     passes_taken_i,
  input  logic                            hit_limit_i,
  input  logic                            cfg_we_i,
  input  logic [nm2d_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [nm2d_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  output int                              errors_o,
  output int                              outstanding_o
);
  import nm2d_pkg::*;

  typedef logic signed [63:0] crd_t;
  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [63:0] value;
    logic [15:0] passes;
    logic        hit;
  } minimum_t;

  crd_t        tgt_x = crd_t'(TARGET_X_RST);
  crd_t        tgt_y = crd_t'(TARGET_Y_RST);
  logic [63:0] spread_thr = THRESHOLD_RST;
  logic [15:0] pass_cap = MAX_ITER_RST;

  crd_t        vx[3];
  crd_t        vy[3];
  logic [63:0] vv[3];
  minimum_t    minima_q[$];
  int          errors = 0;
  int          outstanding = 0;

  assign errors_o      = errors;
  assign outstanding_o = outstanding;

  function automatic logic [127:0] square(crd_t d);
    logic [63:0] m;
    m = (d < 0) ? -d : d;
    return {64'd0, m} * {64'd0, m};
  endfunction

  function automatic logic [63:0] bowl(crd_t x, crd_t y);
    logic [127:0] a, b;
    logic [64:0]  s;
    a = square(x - tgt_x);
    b = square(y - tgt_y);
    if (a[127:64] != 0) a = {64'd0, {64{1'b1}}};
    if (b[127:64] != 0) b = {64'd0, {64{1'b1}}};
    s = {1'b0, a[63:0]} + {1'b0, b[63:0]};
    return s[64] ? {64{1'b1}} : s[63:0];
  endfunction

  function automatic bit axis_ok(crd_t a, crd_t b, crd_t c);
    logic [127:0] p;
    p = square(a - b) + square(b - c) + square(a - c);
    return p <= {64'd0, spread_thr} * 128'd6;
  endfunction

  function automatic crd_t sat32(crd_t v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic void put(int i, crd_t x, crd_t y, logic [63:0] v);
    vx[i] = x;
    vy[i] = y;
    vv[i] = v;
  endfunction

  function automatic void swap(int i, int j);
    crd_t        tx, ty;
    logic [63:0] tv;
    tx = vx[i];
    ty = vy[i];
    tv = vv[i];
    put(i, vx[j], vy[j], vv[j]);
    put(j, tx, ty, tv);
  endfunction

  function automatic void order();
    if (vv[1] < vv[0]) swap(0, 1);
    if (vv[2] < vv[1]) swap(1, 2);
    if (vv[1] < vv[0]) swap(0, 1);
  endfunction

  function automatic void simplex_step();
    crd_t        cx, cy, rx, ry, ex, ey, ix, iy, ox, oy, nx, ny;
    logic [63:0] fr, fe, fi, fo;
    cx = (vx[0] + vx[1]) >>> 1;
    cy = (vy[0] + vy[1]) >>> 1;
    rx = sat32(cx + (cx - vx[2]));
    ry = sat32(cy + (cy - vy[2]));
    ex = sat32(cx + 3 * (cx - vx[2]));
    ey = sat32(cy + 3 * (cy - vy[2]));
    ix = cx + ((vx[2] - cx) >>> 1);
    iy = cy + ((vy[2] - cy) >>> 1);
    ox = cx + ((rx - cx) >>> 1);
    oy = cy + ((ry - cy) >>> 1);
    fr = bowl(rx, ry);
    fe = bowl(ex, ey);
    fi = bowl(ix, iy);
    fo = bowl(ox, oy);
    if (fr < vv[1] && fr >= vv[0]) begin
      put(2, rx, ry, fr);
    end else if (fr < vv[0]) begin
      if (fe < fr) put(2, ex, ey, fe);
      else put(2, rx, ry, fr);
    end else if (fr < vv[2] && fi <= fr) begin
      put(2, ix, iy, fi);
    end else if (fr < vv[2] && fo < vv[2]) begin
      put(2, ox, oy, fo);
    end else begin
      for (int k = 1; k < 3; k++) begin
        nx = vx[0] + ((vx[k] - vx[0]) >>> 1);
        ny = vy[0] + ((vy[k] - vy[0]) >>> 1);
        put(k, nx, ny, bowl(nx, ny));
      end
      order();
    end
  endfunction

  function automatic minimum_t minimize(logic [31:0] s[6]);
    minimum_t    r;
    logic [15:0] n;
    r.hit = 1'b0;
    n = '0;
    for (int k = 0; k < 3; k++) begin
      vx[k] = crd_t'($signed(s[2*k]));
      vy[k] = crd_t'($signed(s[2*k+1]));
      vv[k] = bowl(vx[k], vy[k]);
    end
    order();
    forever begin
      if (axis_ok(vx[0], vx[1], vx[2]) && axis_ok(vy[0], vy[1], vy[2])) break;
      if (n >= pass_cap || n == 16'hffff) begin
        r.hit = 1'b1;
        break;
      end
      n++;
      order();
      simplex_step();
    end
    order();
    r.x = vx[0][31:0];
    r.y = vy[0][31:0];
    r.value = vv[0];
    r.passes = n;
    return r;
  endfunction

  always @(posedge clk_i) begin
    minimum_t    e;
    logic [31:0] s[6];
    if (rst_ni) begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_TARGET_X:  tgt_x = crd_t'($signed(cfg_wdata_i[31:0]));
          REG_TARGET_Y:  tgt_y = crd_t'($signed(cfg_wdata_i[31:0]));
          REG_THRESHOLD: spread_thr = cfg_wdata_i;
          REG_MAX_ITER:  pass_cap = cfg_wdata_i[15:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        s = '{start_ax_i, start_ay_i, start_bx_i, start_by_i, start_cx_i, start_cy_i};
        minima_q.push_back(minimize(s));
      end
      if (out_valid_i && !out_stall_i) begin
        if (minima_q.size() == 0) begin
          $error("result transfer with no expectation waiting");
          errors++;
        end else begin
          e = minima_q.pop_front();
          if (best_x_i !== e.x) begin
            $error("best_x: expected %h, got %h", e.x, best_x_i);
            errors++;
          end
          if (best_y_i !== e.y) begin
            $error("best_y: expected %h, got %h", e.y, best_y_i);
            errors++;
          end
          if (best_value_i !== e.value) begin
            $error("best_value: expected %h, got %h", e.value, best_value_i);
            errors++;
          end
          if (passes_taken_i !== e.passes) begin
            $error("passes_taken: expected %0d, got %0d", e.passes, passes_taken_i);
            errors++;
          end
          if (hit_limit_i !== e.hit) begin
            $error("hit_limit: expected %b, got %b", e.hit, hit_limit_i);
            errors++;
          end
        end
      end
      outstanding = minima_q.size();
    end
  end

endmodule

### tb/tb_nelder_mead_2d_minimizer_unit.sv
// tb_nelder_mead_2d_minimizer_unit: stimulus and verdict for the simplex minimizer.
// Drives directed and random start triangles under changing register settings.
// Depends on nm2d_pkg, nelder_mead_2d_minimizer_unit and nm2d_result_checker.
module tb_nelder_mead_2d_minimizer_unit;
  import nm2d_pkg::*;

  localparam int IDLE_LIMIT = 2500000;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  logic [31:0]           start_ax_i = '0, start_ay_i = '0, start_bx_i = '0;
  logic [31:0]           start_by_i = '0, start_cx_i = '0, start_cy_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b1;
  logic [31:0]           best_x_o, best_y_o;
  logic [63:0]           best_value_o;
  logic [15:0]           passes_taken_o;
  logic                  hit_limit_o;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;
  int                    errors, outstanding;
  int                    idle_cycles = 0;
  logic [31:0]           tx = TARGET_X_RST;
  logic [31:0]           ty = TARGET_Y_RST;

  always #6 clk_i = ~clk_i;

  nelder_mead_2d_minimizer_unit dut (.*);

  nm2d_result_checker checker_i (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o),
    .start_ax_i, .start_ay_i, .start_bx_i, .start_by_i, .start_cx_i, .start_cy_i,
    .out_valid_i(out_valid_o), .out_stall_i,
    .best_x_i(best_x_o), .best_y_i(best_y_o), .best_value_i(best_value_o),
    .passes_taken_i(passes_taken_o), .hit_limit_i(hit_limit_o),
    .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .errors_o(errors), .outstanding_o(outstanding)
  );

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // hold off long once at the start, then stall in random bursts
  initial begin
    int n;
    repeat (600) @(posedge clk_i);
    forever begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(0, 3);
      out_stall_i <= (n != 0);
      repeat (n) @(posedge clk_i);
      out_stall_i <= 1'b0;
      n = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 6);
      repeat (n) @(posedge clk_i);
    end
  end

  task automatic send(logic [31:0] ax, ay, bx, by, cx, cy);
    int gap;
    gap = ($urandom_range(0, 2) == 0) ? 0 :
          ($urandom_range(0, 9) == 0) ? $urandom_range(10, 50) : $urandom_range(1, 3);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    {start_ax_i, start_ay_i, start_bx_i, start_by_i, start_cx_i, start_cy_i} <=
      {ax, ay, bx, by, cx, cy};
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_target(logic [31:0] x, logic [31:0] y);
    tx = x;
    ty = y;
    write_reg(REG_TARGET_X, {$urandom, x});
    write_reg(REG_TARGET_Y, {$urandom, y});
  endtask

  function automatic logic [31:0] near(logic [31:0] t);
    int sc;
    sc = $urandom_range(0, 30);
    return t + (($urandom & ((32'd1 << sc) - 1)) - (32'd1 << sc) / 2);
  endfunction

  task automatic random_triangle();
    if ($urandom_range(0, 9) < 7) begin
      send(near(tx), near(ty), near(tx), near(ty), near(tx), near(ty));
    end else begin
      send($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    end
  endtask

  initial begin
    logic [63:0] thr;
    int          cap, n;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send(32'h0100_0000, 32'hfb00_0000, 32'h0100_0000, 32'hfb00_0000,
         32'h0100_0000, 32'hfb00_0000);
    send(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
    send(32'h0, 32'h0, 32'h0, 32'h0, 32'h0100_0000, 32'h0);
    send(32'h0, 32'h0, 32'h0100_0000, 32'h0, 32'h0, 32'h0100_0000);
    send(32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000,
         32'h7fff_ffff, 32'h8000_0000);
    send(32'hffff_ffff, 32'hffff_ffff, 32'h8000_0000, 32'h7fff_ffff,
         32'h0000_0001, 32'hffff_ffff);
    send(32'h0300_0000, 32'h0200_0000, 32'hfe00_0000, 32'hfc00_0000,
         32'h0000_8000, 32'hf600_0000);
    drain();

    write_reg(REG_MAX_ITER, 64'd0);
    send(32'h0, 32'h0, 32'h0100_0000, 32'h0, 32'h0, 32'h0100_0000);
    send(32'h0100_0000, 32'hfb00_0000, 32'h0100_0000, 32'hfb00_0000,
         32'h0100_0000, 32'hfb00_0000);
    drain();
    write_reg(REG_MAX_ITER, 64'd1);
    write_reg(REG_THRESHOLD, 64'd0);
    write_reg(3'd5, {$urandom, $urandom});
    set_target(32'h7fff_ffff, 32'h8000_0000);
    send(32'h7fff_ff00, 32'h8000_0010, 32'h0, 32'h0, 32'h7fff_fff0, 32'h8000_0100);
    send(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000,
         32'h7fff_ffff, 32'h7fff_ffff);
    drain();
    write_reg(REG_THRESHOLD, 64'hffff_ffff_ffff_ffff);
    write_reg(REG_MAX_ITER, 64'hffff);
    send(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000,
         32'h0, 32'h0);
    send($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    drain();

    for (int ph = 0; ph < 10; ph++) begin
      case ($urandom_range(0, 3))
        0: thr = {$urandom, $urandom};
        1: thr = 64'($urandom_range(0, 5000));
        2: thr = '0;
        default: thr = 64'($urandom_range(100, 400));
      endcase
      cap = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 60);
      if (ph == 9) begin
        thr = '1;
        cap = 65535;
      end
      case ($urandom_range(0, 3))
        0: set_target(32'h7fff_ffff, 32'h8000_0000);
        1: set_target(32'h8000_0000, 32'h7fff_ffff);
        2: set_target($urandom_range(0, 32'h0400_0000), -$urandom_range(0, 32'h0400_0000));
        default: set_target($urandom, $urandom);
      endcase
      write_reg(REG_THRESHOLD, thr);
      write_reg(REG_MAX_ITER, {$urandom, 16'(cap)});
      write_reg(3'($urandom_range(4, 7)), {$urandom, $urandom});
      n = $urandom_range(25, 32);
      repeat (n) random_triangle();
      drain();
    end

    drain();
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
sv/nm2d_pkg.sv
sv/nm2d_sq_unit.sv
sv/nelder_mead_2d_minimizer_unit.sv
tb/nm2d_result_checker.sv
tb/tb_nelder_mead_2d_minimizer_unit.sv
